>>> rtl/lprp_pkg.sv
// lprp_pkg: shared types and constants for the length-prefixed record parser
// holds the input beat and result structs, field kind codes and queue sizing
// no dependencies
`default_nettype none

package lprp_pkg;

  localparam int unsigned KEY_LENGTH_RESET = 66;

  // field kind codes carried in field_kind
  localparam logic [2:0] KIND_KEY   = 3'd0;
  localparam logic [2:0] KIND_HASH  = 3'd1;
  localparam logic [2:0] KIND_BODY  = 3'd2;
  localparam logic [2:0] KIND_NONCE = 3'd3;
  localparam logic [2:0] KIND_TTL   = 3'd4;
  localparam logic [2:0] KIND_TS    = 3'd5;

  // result queue between parser and output side
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       blob_last;
  } in_t;

  typedef struct packed {
    logic [2:0]  field_kind;
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic [63:0] int_value;
    logic        field_end;
    logic        message_end;
    logic        blob_error;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/length_prefixed_record_parser_top.sv
// output: each result is written into the result queue register and presented from there, not combinationally
// throughput: one byte per cycle while in_stall is low; the parser loop updates phase and a 64-bit counter per beat
// a four-entry result queue lets the input keep flowing while the output is stalled
// in_stall rises only when that queue is full
// reset (rst, synchronous): parser restarts at the key, queue empties, key_length returns to 66
// cfg_ready is always high; key_length is written on any cfg_valid beat
`default_nettype none

module length_prefixed_record_parser_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire lprp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lprp_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [7:0]     cfg_data
);
  import lprp_pkg::*;

  logic full;
  logic accept;
  logic push;
  out_t push_data;

  assign in_stall  = full;
  assign accept    = in_valid && !full;
  assign cfg_ready = 1'b1;

  lprp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data)
  );

  lprp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/lprp_front.sv
// lprp_front: byte parser, tracks field phase, length counters and integer assembly
// emits at most one result per accepted byte; depends on lprp_pkg
`default_nettype none

module lprp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire lprp_pkg::in_t in_data,
  input  wire logic          cfg_write,
  input  wire logic [7:0]    cfg_data,
  output logic               push,
  output lprp_pkg::out_t     push_data
);
  import lprp_pkg::*;

  typedef enum logic [8:0] {
    PH_KEY  = 9'b000000001,
    PH_HLEN = 9'b000000010,
    PH_HDAT = 9'b000000100,
    PH_BLEN = 9'b000001000,
    PH_BDAT = 9'b000010000,
    PH_TTL  = 9'b000100000,
    PH_TS   = 9'b001000000,
    PH_NLEN = 9'b010000000,
    PH_NDAT = 9'b100000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] remaining_count, remaining_count_next;
  logic [63:0] assemble_shift, assemble_shift_next;
  logic [2:0]  int_byte_index, int_byte_index_next;
  logic [7:0]  key_length;

  logic [8:0]  key_limit;
  logic [8:0]  key_cnt;
  logic [63:0] word;
  logic        have, bv, fe, me, err;
  logic [63:0] iv;
  logic [2:0]  kind;

  assign key_limit = (key_length == 8'd0) ? 9'd256 : {1'b0, key_length};
  // key phase count never exceeds 255, so the low bits carry it
  assign key_cnt   = remaining_count[8:0] + 9'd1;
  assign word      = {in_data.in_byte, assemble_shift[55:0]};

  always_comb begin
    phase_next           = phase;
    remaining_count_next = remaining_count;
    assemble_shift_next  = assemble_shift;
    int_byte_index_next  = int_byte_index;
    have = 1'b0;
    bv   = 1'b0;
    fe   = 1'b0;
    me   = 1'b0;
    iv   = 64'd0;
    kind = KIND_KEY;
    case (phase)
      PH_KEY: begin
        have = 1'b1;
        bv   = 1'b1;
        if (key_cnt >= key_limit) begin
          fe                   = 1'b1;
          phase_next           = PH_HLEN;
          remaining_count_next = 64'd0;
        end else begin
          remaining_count_next = {55'd0, key_cnt};
        end
      end
      PH_HLEN, PH_BLEN, PH_NLEN: begin
        kind = (phase == PH_HLEN) ? KIND_HASH :
               (phase == PH_BLEN) ? KIND_BODY : KIND_NONCE;
        if (int_byte_index == 3'd7) begin
          assemble_shift_next = 64'd0;
          int_byte_index_next = 3'd0;
          if (word == 64'd0) begin
            // empty string: field end with no byte
            have = 1'b1;
            fe   = 1'b1;
            remaining_count_next = 64'd0;
            case (phase)
              PH_HLEN: phase_next = PH_BLEN;
              PH_BLEN: phase_next = PH_TTL;
              default: begin
                phase_next = PH_KEY;
                me         = 1'b1;
              end
            endcase
          end else begin
            remaining_count_next = word;
            case (phase)
              PH_HLEN: phase_next = PH_HDAT;
              PH_BLEN: phase_next = PH_BDAT;
              default: phase_next = PH_NDAT;
            endcase
          end
        end else begin
          assemble_shift_next[{int_byte_index, 3'b000} +: 8] = in_data.in_byte;
          int_byte_index_next = int_byte_index + 3'd1;
        end
      end
      PH_HDAT, PH_BDAT, PH_NDAT: begin
        kind = (phase == PH_HDAT) ? KIND_HASH :
               (phase == PH_BDAT) ? KIND_BODY : KIND_NONCE;
        have = 1'b1;
        bv   = 1'b1;
        if (remaining_count <= 64'd1) begin
          fe = 1'b1;
          remaining_count_next = 64'd0;
          case (phase)
            PH_HDAT: phase_next = PH_BLEN;
            PH_BDAT: phase_next = PH_TTL;
            default: begin
              phase_next = PH_KEY;
              me         = 1'b1;
            end
          endcase
        end else begin
          remaining_count_next = remaining_count - 64'd1;
        end
      end
      PH_TTL, PH_TS: begin
        kind = (phase == PH_TTL) ? KIND_TTL : KIND_TS;
        if (int_byte_index == 3'd7) begin
          have = 1'b1;
          fe   = 1'b1;
          iv   = word;
          assemble_shift_next  = 64'd0;
          int_byte_index_next  = 3'd0;
          remaining_count_next = 64'd0;
          phase_next = (phase == PH_TTL) ? PH_TS : PH_NLEN;
        end else begin
          assemble_shift_next[{int_byte_index, 3'b000} +: 8] = in_data.in_byte;
          int_byte_index_next = int_byte_index + 3'd1;
        end
      end
      default: begin
        phase_next           = PH_KEY;
        remaining_count_next = 64'd0;
        assemble_shift_next  = 64'd0;
        int_byte_index_next  = 3'd0;
      end
    endcase

    // blob ended inside a record: flag it and restart
    err = in_data.blob_last && !me;
    if (err) begin
      have                 = 1'b1;
      phase_next           = PH_KEY;
      remaining_count_next = 64'd0;
      assemble_shift_next  = 64'd0;
      int_byte_index_next  = 3'd0;
    end
  end

  assign push                  = accept && have;
  assign push_data.field_kind  = kind;
  assign push_data.byte_valid  = bv;
  assign push_data.byte_value  = bv ? in_data.in_byte : 8'd0;
  assign push_data.int_value   = iv;
  assign push_data.field_end   = fe;
  assign push_data.message_end = me;
  assign push_data.blob_error  = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_KEY;
      remaining_count <= 64'd0;
      assemble_shift  <= 64'd0;
      int_byte_index  <= 3'd0;
      key_length      <= 8'(KEY_LENGTH_RESET);
    end else begin
      if (accept) begin
        phase           <= phase_next;
        remaining_count <= remaining_count_next;
        assemble_shift  <= assemble_shift_next;
        int_byte_index  <= int_byte_index_next;
      end
      if (cfg_write) begin
        key_length <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lprp_queue.sv
// lprp_queue: small result queue between parser and output side
// register based, one write and one read per cycle, the read held while out_stall is high; depends on lprp_pkg
`default_nettype none

module lprp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lprp_pkg::out_t push_data,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lprp_pkg::out_t      out_data
);
  import lprp_pkg::*;

  out_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/lprp_chk.sv
// lprp_chk: port-level checks on the record parser results
// bound to length_prefixed_record_parser_top; depends on lprp_pkg
`default_nettype none

module lprp_chk (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           out_valid,
  input  wire logic           out_stall,
  input  wire lprp_pkg::out_t out_data
);
  import lprp_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // record completion only on a clean nonce end
  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.message_end |->
      out_data.field_end && out_data.field_kind == KIND_NONCE && !out_data.blob_error)
    else $error("message_end on a bad result");

  // payload bytes only belong to key and string fields
  a_byte_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_valid |->
      out_data.field_kind == KIND_KEY || out_data.field_kind == KIND_HASH ||
      out_data.field_kind == KIND_BODY || out_data.field_kind == KIND_NONCE)
    else $error("byte on an integer field");

  // integer value is zero except on a completed ttl or timestamp
  a_int_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.field_kind != KIND_TTL && out_data.field_kind != KIND_TS |->
      out_data.int_value == 64'd0)
    else $error("int_value on a non-integer field");

  // a beat without a byte carries a zero byte value
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.byte_value == 8'd0)
    else $error("byte_value set without byte_valid");

endmodule

bind length_prefixed_record_parser_top lprp_chk u_lprp_chk (.*);

`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking testbench for length_prefixed_record_parser_top
// builds blobs of records, predicts every result beat and checks the output stream
// depends on rtl/lprp_pkg.sv and rtl/length_prefixed_record_parser_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lprp_pkg::*;

  typedef enum logic [3:0] {
    PH_KEY, PH_HASH_LEN, PH_HASH_DATA, PH_BODY_LEN, PH_BODY_DATA,
    PH_TTL, PH_STAMP, PH_NONCE_LEN, PH_NONCE_DATA
  } parse_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  // idle rates in percent
  int in_gap_pct = 11;
  int out_stall_pct = 64;
  int mismatches = 0;
  int beats_sent = 0;

  // parser shadow state
  parse_phase_e parse_phase = PH_KEY;
  logic [63:0] field_left = '0;
  logic [63:0] shift_acc = '0;
  logic [2:0]  int_idx = '0;
  logic [7:0]  key_len_cfg = 8'(KEY_LENGTH_RESET);

  out_t expected_results[$];
  in_t  blob_bytes[$];

  length_prefixed_record_parser_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < 200)
      $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [2:0] kind_of(parse_phase_e p);
    case (p)
      PH_HASH_LEN, PH_HASH_DATA:   return KIND_HASH;
      PH_BODY_LEN, PH_BODY_DATA:   return KIND_BODY;
      PH_NONCE_LEN, PH_NONCE_DATA: return KIND_NONCE;
      PH_TTL:                      return KIND_TTL;
      PH_STAMP:                    return KIND_TS;
      default:                     return KIND_KEY;
    endcase
  endfunction

  function automatic void restart_record();
    parse_phase = PH_KEY;
    field_left = '0;
    shift_acc = '0;
    int_idx = '0;
  endfunction

  // step to the next field; returns 1 when the nonce closed a record
  function automatic bit advance_field();
    shift_acc = '0;
    int_idx = '0;
    field_left = '0;
    case (parse_phase)
      PH_HASH_LEN, PH_HASH_DATA: parse_phase = PH_BODY_LEN;
      PH_BODY_LEN, PH_BODY_DATA: parse_phase = PH_TTL;
      PH_TTL:                    parse_phase = PH_STAMP;
      PH_STAMP:                  parse_phase = PH_NONCE_LEN;
      default: begin
        restart_record();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void predict_parse(in_t d);
    out_t res;
    bit have, done;
    logic [63:0] limit, cnt, len;
    res = '0;
    have = 1'b0;
    done = 1'b0;
    res.field_kind = kind_of(parse_phase);
    case (parse_phase)
      PH_KEY: begin
        have = 1'b1;
        res.byte_valid = 1'b1;
        limit = (key_len_cfg == 8'd0) ? 64'd256 : 64'(key_len_cfg);
        cnt = field_left + 64'd1;
        if (cnt >= limit) begin
          res.field_end = 1'b1;
          void'(advance_field());
          parse_phase = PH_HASH_LEN;
        end else begin
          field_left = cnt;
        end
      end
      PH_HASH_LEN, PH_BODY_LEN, PH_NONCE_LEN: begin
        shift_acc |= 64'(d.in_byte) << (8 * int_idx);
        if (int_idx == 3'd7) begin
          len = shift_acc;
          shift_acc = '0;
          int_idx = '0;
          if (len == 64'd0) begin
            // empty string still closes its field
            have = 1'b1;
            res.field_end = 1'b1;
            done = advance_field();
          end else begin
            field_left = len;
            parse_phase = parse_phase_e'(parse_phase + 4'd1);
          end
        end else begin
          int_idx++;
        end
      end
      PH_HASH_DATA, PH_BODY_DATA, PH_NONCE_DATA: begin
        have = 1'b1;
        res.byte_valid = 1'b1;
        if (field_left <= 64'd1) begin
          res.field_end = 1'b1;
          done = advance_field();
        end else begin
          field_left--;
        end
      end
      default: begin
        shift_acc |= 64'(d.in_byte) << (8 * int_idx);
        if (int_idx == 3'd7) begin
          have = 1'b1;
          res.int_value = shift_acc;
          res.field_end = 1'b1;
          done = advance_field();
        end else begin
          int_idx++;
        end
      end
    endcase
    if (res.byte_valid)
      res.byte_value = d.in_byte;
    res.message_end = done;
    // blob ended inside a record
    if (d.blob_last && !done) begin
      have = 1'b1;
      res.blob_error = 1'b1;
      restart_record();
    end
    if (have)
      expected_results.insert(expected_results.size(), res);
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(out_data), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.field_kind !== want.field_kind)
          report_mismatch("field_kind", 64'(out_data.field_kind), 64'(want.field_kind));
        if (out_data.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", 64'(out_data.byte_valid), 64'(want.byte_valid));
        if (out_data.byte_value !== want.byte_value)
          report_mismatch("byte_value", 64'(out_data.byte_value), 64'(want.byte_value));
        if (out_data.int_value !== want.int_value)
          report_mismatch("int_value", out_data.int_value, want.int_value);
        if (out_data.field_end !== want.field_end)
          report_mismatch("field_end", 64'(out_data.field_end), 64'(want.field_end));
        if (out_data.message_end !== want.message_end)
          report_mismatch("message_end", 64'(out_data.message_end), 64'(want.message_end));
        if (out_data.blob_error !== want.blob_error)
          report_mismatch("blob_error", 64'(out_data.blob_error), 64'(want.blob_error));
      end
    end
  end

  task automatic send_beat(in_t d);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_parse(d);
    beats_sent++;
  endtask

  // sender holds off until every expected beat has come back or the guard runs out
  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_key_length(logic [7:0] v);
    wait_for_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    key_len_cfg = v;
  endtask

  function automatic void push_byte(logic [7:0] b);
    in_t d;
    d.in_byte = b;
    d.blob_last = 1'b0;
    blob_bytes.insert(blob_bytes.size(), d);
  endfunction

  function automatic void push_le64(logic [63:0] v);
    for (int i = 0; i < 8; i++)
      push_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_string(int len);
    push_le64(64'(len));
    for (int i = 0; i < len; i++)
      push_byte(8'($urandom));
  endfunction

  function automatic int pick_string_len();
    return ($urandom_range(7) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
  endfunction

  function automatic void push_key(int n);
    for (int i = 0; i < n; i++)
      push_byte(8'($urandom));
  endfunction

  function automatic void push_record();
    push_key((key_len_cfg == 8'd0) ? 256 : int'(key_len_cfg));
    push_string(pick_string_len());
    push_string(pick_string_len());
    push_le64({$urandom, $urandom});
    push_le64({$urandom, $urandom});
    push_string(pick_string_len());
  endfunction

  function automatic void mark_last();
    blob_bytes[blob_bytes.size() - 1].blob_last = 1'b1;
  endfunction

  task automatic send_blob();
    while (blob_bytes.size() != 0)
      send_beat(blob_bytes.pop_front());
  endtask

  task automatic test_reset_key_length();
    push_record();
    mark_last();
    send_blob();
  endtask

  task automatic test_fields_and_truncation();
    write_key_length(8'd1);
    // empty hash, one-byte body, extreme integers, clean end on the nonce
    push_byte(8'hA5);
    push_le64(64'd0);
    push_le64(64'd1);
    push_byte(8'hFF);
    push_le64('1);
    push_le64('0);
    push_le64(64'd1);
    push_byte(8'h00);
    mark_last();
    send_blob();
    // blob ends on the key byte that finishes the key
    push_byte(8'h5A);
    mark_last();
    send_blob();
    // blob ends inside a length prefix
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'h00);
    mark_last();
    send_blob();
    // blob ends on the last payload byte of the hash
    push_byte(8'h33);
    push_string(1);
    mark_last();
    send_blob();
    // blob ends on the byte that completes the ttl
    push_byte(8'h77);
    push_string(0);
    push_string(0);
    push_le64(64'h8000_0000_0000_0001);
    mark_last();
    send_blob();
    // blob ends partway through the timestamp
    push_byte(8'h11);
    push_string(0);
    push_string(0);
    push_le64(64'h0123_4567_89AB_CDEF);
    push_byte(8'hC3);
    mark_last();
    send_blob();
    // blob ends on a key byte before the key is done
    write_key_length(8'd2);
    push_byte(8'h80);
    mark_last();
    send_blob();
  endtask

  task automatic test_key_length_extremes();
    // zero means 256 key bytes: the error kind shows the key ended
    write_key_length(8'd0);
    push_key(256);
    push_byte(8'h04);
    mark_last();
    send_blob();
  endtask

  task automatic test_key_length_change_mid_key();
    // shrink below the count already taken: next key byte ends the key
    write_key_length(8'd8);
    push_key(5);
    send_blob();
    write_key_length(8'd3);
    push_key(1);
    push_string(0);
    push_string(2);
    push_le64({$urandom, $urandom});
    push_le64({$urandom, $urandom});
    push_string(0);
    mark_last();
    send_blob();
    // grow while inside the key
    write_key_length(8'd4);
    push_key(2);
    send_blob();
    write_key_length(8'd6);
    push_key(4);
    push_string(1);
    push_string(0);
    push_le64({$urandom, $urandom});
    push_le64({$urandom, $urandom});
    push_string(3);
    mark_last();
    send_blob();
  endtask

  task automatic test_huge_length();
    write_key_length(8'd1);
    push_byte(8'h42);
    push_le64('1);
    repeat (6) push_byte(8'($urandom));
    mark_last();
    send_blob();
  endtask

  task automatic test_random_blobs(int n_beats);
    int start, sel, cut;
    bit paused;
    start = beats_sent;
    paused = 1'b0;
    while (beats_sent - start < n_beats) begin
      if ($urandom_range(2) == 0)
        write_key_length(($urandom_range(9) == 0) ? 8'd66 : 8'($urandom_range(1, 8)));
      sel = $urandom_range(9);
      if (sel <= 5) begin
        repeat ($urandom_range(1, 3)) push_record();
        mark_last();
      end else if (sel <= 8) begin
        push_record();
        cut = $urandom_range(0, blob_bytes.size() - 1);
        while (blob_bytes.size() > cut + 1) void'(blob_bytes.pop_back());
        mark_last();
      end else begin
        // noise, always closed so the parser gets back to a key
        repeat ($urandom_range(1, 12)) begin
          push_byte(8'($urandom));
          blob_bytes[blob_bytes.size() - 1].blob_last = ($urandom_range(3) == 0);
        end
        mark_last();
      end
      send_blob();
      if (!paused && beats_sent - start > n_beats / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key_length();
    test_fields_and_truncation();
    test_key_length_extremes();
    test_key_length_change_mid_key();
    test_huge_length();
    test_random_blobs(30);
    in_gap_pct = 64;
    out_stall_pct = 11;
    test_random_blobs(30);
    in_gap_pct = 0;
    out_stall_pct = 0;
    test_random_blobs(30);
    wait_for_results();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 64'(expected_results.size()), '0);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/lprp_pkg.sv
rtl/lprp_front.sv
rtl/lprp_queue.sv
rtl/length_prefixed_record_parser_top.sv
rtl/lprp_chk.sv
dv/tb_top.sv
